### rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  // Widths of the result fields.
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int STATUS_W  = 2;
  localparam int CMD_W     = 2;

  // Operation codes carried by the input transaction.
  typedef enum logic [CMD_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DIVZERO = 2'd2
  } status_t;

  // Which cross product the shared multiplier forms.
  typedef enum logic [1:0] {
    MUL_NUM0 = 2'd0,
    MUL_NUM1 = 2'd1,
    MUL_DEN  = 2'd2
  } mul_sel_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL0 = 3'd1,
    S_MUL1 = 3'd2,
    S_MUL2 = 3'd3,
    S_ABS  = 3'd4,
    S_GCD  = 3'd5,
    S_DIV  = 3'd6,
    S_DONE = 3'd7
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     ld_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_init;
    logic     acc_upd;
    logic     abs_ld;
    logic     gcd_step;
    logic     div_step;
    logic     ld_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_err;
    logic gcd_done;
  } dp_stat_t;

endpackage

### rtl/rau_ctrl.sv
// Controller state machine that sequences multiply, reduce and divide steps.
module rau_ctrl #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rau_pkg::dp_stat_t  stat,
  output rau_pkg::dp_cmd_t   cmd
);
  import rau_pkg::*;

  localparam int DW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;
  logic          out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = stat.in_err ? S_DONE : S_MUL0;
        end
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_ABS;
      S_ABS:  state_nxt = S_GCD;
      S_GCD: begin
        if (stat.gcd_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output and command logic.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NUM0;
      end
      S_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_NUM1;
        cmd.acc_init = 1'b1;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEN;
        cmd.acc_upd = 1'b1;
      end
      S_ABS:  cmd.abs_ld   = 1'b1;
      S_GCD:  cmd.gcd_step = !stat.gcd_done;
      S_DIV:  cmd.div_step = 1'b1;
      S_DONE: cmd.ld_out   = out_free;
      default: cmd = '0;
    endcase
  end

  // Divide step counter and result valid flag.
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == S_DIV) begin
      cnt_nxt = cnt_r + CW'(1);
    end else begin
      cnt_nxt = '0;
    end
    out_valid_nxt = cmd.ld_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/rau_dpath.sv
// Datapath: cross products, binary GCD, shared-divisor divide and result register.
module rau_dpath #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [rau_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_den,
  input  rau_pkg::dp_cmd_t                     cmd,
  output rau_pkg::dp_stat_t                    stat,
  output logic signed [rau_pkg::RES_NUM_W-1:0] out_res_num,
  output logic [rau_pkg::RES_DEN_W-1:0]        out_res_den,
  output logic [rau_pkg::STATUS_W-1:0]         out_status
);
  import rau_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int DW    = 2 * W;
  localparam int NEXTW = (DW + 1 > RES_NUM_W) ? DW + 1 : RES_NUM_W;
  localparam int DEXTW = (DW > RES_DEN_W) ? DW : RES_DEN_W;

  // Captured operands.
  op_t                 op_r;
  status_t             err_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;

  // Products and numerator accumulator.
  logic signed [DW-1:0] prod_r;
  logic signed [DW:0]   p_r;
  logic                 neg_r;

  // GCD operands and the dividends that follow the common factors of two.
  logic [DW-1:0] u_r, v_r;
  logic [DW-1:0] dn_r, dq_r;
  logic [DW-1:0] rn_r, rq_r;

  // Result register.
  logic signed [RES_NUM_W-1:0] res_num_r;
  logic [RES_DEN_W-1:0]        res_den_r;
  status_t                     res_st_r;

  // Input checks.
  status_t in_st;
  always_comb begin
    if (in_a_den == '0 || in_b_den == '0) begin
      in_st = ST_INVALID;
    end else if (op_t'(in_cmd) == OP_DIV && in_b_num == '0) begin
      in_st = ST_DIVZERO;
    end else begin
      in_st = ST_OK;
    end
  end

  assign stat.in_err   = (in_st != ST_OK);
  assign stat.gcd_done = (u_r == '0);

  // Operand selection for the shared multiplier.
  logic signed [W-1:0]  mx, my;
  logic signed [DW-1:0] mul_res;
  always_comb begin
    mx = an_r;
    my = bd_r;
    case (cmd.mul_sel)
      MUL_NUM0: begin
        mx = an_r;
        my = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      MUL_NUM1: begin
        mx = bn_r;
        my = (op_r == OP_ADD || op_r == OP_SUB) ? ad_r : '0;
      end
      MUL_DEN: begin
        mx = ad_r;
        my = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end
  assign mul_res = mx * my;

  // Numerator accumulate and magnitudes.
  logic signed [DW:0] prod_ext, acc_val, p_neg;
  logic signed [DW-1:0] q_neg;
  logic [DW-1:0] mag_p, mag_q;
  always_comb begin
    prod_ext = (DW + 1)'(prod_r);
    acc_val  = (op_r == OP_SUB) ? (p_r - prod_ext) : (p_r + prod_ext);
    p_neg    = -p_r;
    q_neg    = -prod_r;
    mag_p    = p_r[DW] ? p_neg[DW-1:0] : p_r[DW-1:0];
    mag_q    = prod_r[DW-1] ? q_neg : prod_r;
  end

  // One binary GCD step.
  logic [DW-1:0] d_uv, d_vu;
  logic          u_ge;
  assign u_ge = (u_r >= v_r);
  assign d_uv = u_r - v_r;
  assign d_vu = v_r - u_r;

  // One restoring divide step on both lanes, sharing the divisor.
  logic [DW:0]   sh_n, sh_q, sub_n, sub_q;
  logic          ge_n, ge_q;
  logic [DW-1:0] rn_nxt, rq_nxt;
  always_comb begin
    sh_n   = {rn_r, dn_r[DW-1]};
    sh_q   = {rq_r, dq_r[DW-1]};
    sub_n  = sh_n - {1'b0, v_r};
    sub_q  = sh_q - {1'b0, v_r};
    ge_n   = (sh_n >= {1'b0, v_r});
    ge_q   = (sh_q >= {1'b0, v_r});
    rn_nxt = ge_n ? sub_n[DW-1:0] : sh_n[DW-1:0];
    rq_nxt = ge_q ? sub_q[DW-1:0] : sh_q[DW-1:0];
  end

  // Signed result fitted to the output widths.
  logic signed [DW:0]    num_full;
  logic signed [NEXTW-1:0] num_ext;
  logic [DEXTW-1:0]      den_ext;
  always_comb begin
    num_full = neg_r ? -$signed({1'b0, dn_r}) : $signed({1'b0, dn_r});
    num_ext  = NEXTW'(num_full);
    den_ext  = DEXTW'(dq_r);
  end

  // Operand capture and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r  <= op_t'(in_cmd);
      err_r <= in_st;
      an_r  <= in_a_num;
      ad_r  <= in_a_den;
      bn_r  <= in_b_num;
      bd_r  <= in_b_den;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_res;
    end
    if (cmd.acc_init) begin
      p_r <= prod_ext;
    end else if (cmd.acc_upd) begin
      p_r <= acc_val;
    end
    if (cmd.abs_ld) begin
      neg_r <= p_r[DW] ^ prod_r[DW-1];
      u_r   <= mag_p;
      v_r   <= mag_q;
      dn_r  <= mag_p;
      dq_r  <= mag_q;
      rn_r  <= '0;
      rq_r  <= '0;
    end else if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r  <= u_r >> 1;
        v_r  <= v_r >> 1;
        dn_r <= dn_r >> 1;
        dq_r <= dq_r >> 1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_ge) begin
        u_r <= d_uv >> 1;
      end else begin
        v_r <= d_vu >> 1;
      end
    end else if (cmd.div_step) begin
      rn_r <= rn_nxt;
      rq_r <= rq_nxt;
      dn_r <= {dn_r[DW-2:0], ge_n};
      dq_r <= {dq_r[DW-2:0], ge_q};
    end
  end

  // Result register; an error gives the fraction zero over one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_st_r  <= ST_OK;
      res_num_r <= '0;
      res_den_r <= RES_DEN_W'(1);
    end else if (cmd.ld_out) begin
      res_st_r <= err_r;
      if (err_r != ST_OK) begin
        res_num_r <= '0;
        res_den_r <= RES_DEN_W'(1);
      end else begin
        res_num_r <= num_ext[RES_NUM_W-1:0];
        res_den_r <= den_ext[RES_DEN_W-1:0];
      end
    end
  end

  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = res_st_r;

endmodule

### rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
// Each input transaction carries two fractions and an operation (add, subtract,
// multiply, divide) and yields one result transaction: the exact result reduced
// to lowest terms with a positive denominator, zero given as 0/1. A zero input
// denominator returns status invalid argument, and a divide by a zero numerator
// returns division by zero, both with the fraction 0/1.
// A normal transaction runs an accept step, the cross products on the shared
// multiplier, a magnitude step, a binary GCD loop of one step per cycle (at most
// about 4*OPERAND_WIDTH steps, usually far fewer), 2*OPERAND_WIDTH restoring
// divide steps and a result write; its length is set mainly by the GCD loop and
// the divider. One transaction is worked on at a time; the next is accepted
// while a finished result still waits at the output.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rau_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_den,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rau_pkg::RES_NUM_W-1:0] out_res_num,
  output logic [rau_pkg::RES_DEN_W-1:0]        out_res_den,
  output logic [rau_pkg::STATUS_W-1:0]         out_status
);
  import rau_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  rau_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  rau_dpath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (in_cmd),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .cmd         (cmd),
    .stat        (stat),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

endmodule
